[sv/jfp_pkg.sv]
// ----------------------------------------------------------------------------
// jfp_pkg
// Shared types and constants of the Jacobi five-point relaxation sweep.
// ----------------------------------------------------------------------------
package jfp_pkg;

   localparam int MAX_WIDTH_DEF    = 64;
   localparam int VALUE_BITS_DEF   = 32;

   localparam int DATA_BITS        = 32;
   localparam int GRID_WIDTH_BITS  = 7;
   localparam int GRID_HEIGHT_BITS = 16;
   localparam int TOL_BITS         = 32;
   localparam int CSR_DATA_BITS    = 32;
   localparam int CSR_INDEX_BITS   = 2;

   // smallest grid side, narrower settings are raised to it
   localparam int MIN_DIM = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOLERANCE   = 2'd2;

   localparam logic [GRID_WIDTH_BITS-1:0]  GRID_WIDTH_RST  = 7'd64;
   localparam logic [GRID_HEIGHT_BITS-1:0] GRID_HEIGHT_RST = 16'd64;
   localparam logic [TOL_BITS-1:0]         TOLERANCE_RST   = 32'd6554;

   typedef struct packed {
      logic [DATA_BITS-1:0] sample_value;
      logic                 drain;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] new_value;
      logic                 converged;
      logic                 last_of_sweep;
   } rsp_payload_type;

   // classification of one accepted beat
   typedef struct packed {
      logic load;      // beat takes effect
      logic sample;    // beat carries a grid cell
      logic emit;      // beat produces a result
      logic interior;  // result cell is relaxed
      logic last;      // result closes the sweep
   } item_ctl_type;

endpackage

[sv/jacobi_four_point_sweep.sv]
// ----------------------------------------------------------------------------
// jacobi_four_point_sweep
// One Jacobi relaxation sweep with a five-point stencil over a raster stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries grid cells (Q16.16) in raster order; a beat with drain set
//   carries no cell and releases the next cell of the final row once all
//   cells are in. Each effective beat from the second row on gives one rsp_*
//   beat: the cell one row above, relaxed to the floor of the mean of its
//   four neighbors, border cells unchanged. last_of_sweep marks the final
//   cell; converged on it tells whether every interior change stayed below
//   tolerance. Beats that arrive out of turn are taken and dropped.
//   Each beat passes the stage 1 and stage 2 registers and the result
//   register before rsp_valid rises. Throughput: one beat per cycle while
//   req_stall is low; each line store memory is read once per beat
//   (middle row on two ports) with the read data registered.
//   csr_*: a write to any register restarts the sweep; write only when idle.
//   Reset restores 64 x 64, tolerance 6554, and an empty pipeline; no
//   clearing pass is run. When rsp_stall holds, the result register holds
//   its beat and req_stall rises once the three stages are full.
// ----------------------------------------------------------------------------
module jacobi_four_point_sweep import jfp_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);

   logic [GRID_WIDTH_BITS-1:0]  grid_width_ff, grid_width_in;
   logic [GRID_HEIGHT_BITS-1:0] grid_height_ff, grid_height_in;
   logic [TOL_BITS-1:0]         tolerance_ff, tolerance_in;
   logic                        restart;

   logic                  in_ready;
   logic                  req_accept;
   item_ctl_type          item_ctl;
   logic [COL_BITS-1:0]   addr_a, addr_b;
   logic [VALUE_BITS-1:0] sample_value;
   logic [VALUE_BITS-1:0] mid_a, mid_b, up, left;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      tolerance_in   = tolerance_ff;
      restart        = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_WIDTH: begin
               grid_width_in = csr_wdata[GRID_WIDTH_BITS-1:0];
               restart       = 1'b1;
            end
            CSR_GRID_HEIGHT: begin
               grid_height_in = csr_wdata[GRID_HEIGHT_BITS-1:0];
               restart        = 1'b1;
            end
            CSR_TOLERANCE: begin
               tolerance_in = csr_wdata[TOL_BITS-1:0];
               restart      = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RST;
         grid_height_ff <= GRID_HEIGHT_RST;
         tolerance_ff   <= TOLERANCE_RST;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         tolerance_ff   <= tolerance_in;
      end
   end

   assign req_stall    = !in_ready;
   assign req_accept   = req_valid && in_ready;
   assign sample_value = VALUE_BITS'(req_payload.sample_value);

   jfp_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .drain       (req_payload.drain),
      .restart     (restart),
      .grid_width  (grid_width_ff),
      .grid_height (grid_height_ff),
      .item_ctl    (item_ctl),
      .addr_a      (addr_a),
      .addr_b      (addr_b)
   );

   jfp_line_store #(
      .MAX_WIDTH  (MAX_WIDTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_line_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (item_ctl.load),
      .sample   (item_ctl.sample),
      .addr_a   (addr_a),
      .addr_b   (addr_b),
      .wdata    (sample_value),
      .mid_a_ff (mid_a),
      .mid_b_ff (mid_b),
      .up_ff    (up),
      .left_ff  (left)
   );

   jfp_relax #(
      .VALUE_BITS (VALUE_BITS)
   ) u_relax (
      .clock        (clock),
      .reset        (reset),
      .restart      (restart),
      .tolerance    (tolerance_ff),
      .item_ctl     (item_ctl),
      .sample_value (sample_value),
      .mid_a        (mid_a),
      .mid_b        (mid_b),
      .up           (up),
      .left         (left),
      .in_ready     (in_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

endmodule

[sv/jfp_ctrl.sv]
// ----------------------------------------------------------------------------
// jfp_ctrl
// Raster position counters; classifies each accepted beat and drives the
// line store addresses.
// ----------------------------------------------------------------------------
module jfp_ctrl import jfp_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        drain,
   input  logic                        restart,
   input  logic [GRID_WIDTH_BITS-1:0]  grid_width,
   input  logic [GRID_HEIGHT_BITS-1:0] grid_height,
   output item_ctl_type                item_ctl,
   output logic [$clog2(MAX_WIDTH)-1:0] addr_a,
   output logic [$clog2(MAX_WIDTH)-1:0] addr_b
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int GW_BITS  = (GRID_WIDTH_BITS > $clog2(MAX_WIDTH + 1)) ?
                             GRID_WIDTH_BITS : $clog2(MAX_WIDTH + 1);

   logic [COL_BITS-1:0]         col_ff, col_in;
   logic [COL_BITS-1:0]         dcnt_ff, dcnt_in;
   logic [GRID_HEIGHT_BITS-1:0] row_ff, row_in;

   logic [GW_BITS-1:0]          gw_ext;
   logic [GW_BITS-1:0]          w_eff;
   logic [COL_BITS-1:0]         w_last;
   logic [GRID_HEIGHT_BITS-1:0] h_eff;
   logic                        drain_ok;
   logic                        sample_ok;

   // clamp the configured grid size
   always_comb begin
      gw_ext = GW_BITS'(grid_width);
      if (gw_ext < GW_BITS'(MIN_DIM)) begin
         w_eff = GW_BITS'(MIN_DIM);
      end else if (gw_ext > GW_BITS'(MAX_WIDTH)) begin
         w_eff = GW_BITS'(MAX_WIDTH);
      end else begin
         w_eff = gw_ext;
      end
      w_last = COL_BITS'(w_eff - GW_BITS'(1));
      h_eff  = (grid_height < GRID_HEIGHT_BITS'(MIN_DIM)) ?
               GRID_HEIGHT_BITS'(MIN_DIM) : grid_height;
   end

   assign drain_ok  = (row_ff == h_eff) && (dcnt_ff <= w_last);
   assign sample_ok = (row_ff < h_eff) && (col_ff <= w_last);

   always_comb begin
      item_ctl.sample   = !drain;
      item_ctl.load     = accept && (drain ? drain_ok : sample_ok);
      item_ctl.emit     = drain || (row_ff != '0);
      item_ctl.interior = !drain && (row_ff > GRID_HEIGHT_BITS'(1)) &&
                          (col_ff != '0) && (col_ff < w_last);
      item_ctl.last     = drain && (dcnt_ff == w_last);
   end

   assign addr_a = drain ? dcnt_ff : col_ff;
   assign addr_b = (col_ff == COL_BITS'(MAX_WIDTH - 1)) ? '0 : col_ff + COL_BITS'(1);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      dcnt_in = dcnt_ff;
      if (restart) begin
         col_in  = '0;
         row_in  = '0;
         dcnt_in = '0;
      end else if (item_ctl.load) begin
         if (drain) begin
            if (item_ctl.last) begin
               col_in  = '0;
               row_in  = '0;
               dcnt_in = '0;
            end else begin
               dcnt_in = dcnt_ff + COL_BITS'(1);
            end
         end else if (col_ff == w_last) begin
            col_in = '0;
            row_in = row_ff + GRID_HEIGHT_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         dcnt_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         dcnt_ff <= dcnt_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_drain_after_rows: assert property (@(posedge clock) disable iff (reset)
      (dcnt_ff != '0) |-> (row_ff == h_eff))
      else $error("drain count advanced before all rows were received");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= w_last)
      else $error("column count beyond grid width");
`endif

endmodule

[sv/jfp_line_store.sv]
// ----------------------------------------------------------------------------
// jfp_line_store
// Two row memories (middle and upper) with registered reads, plus the
// left-neighbor register.
// ----------------------------------------------------------------------------
module jfp_line_store import jfp_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic                         sample,
   input  logic [$clog2(MAX_WIDTH)-1:0] addr_a,
   input  logic [$clog2(MAX_WIDTH)-1:0] addr_b,
   input  logic [VALUE_BITS-1:0]        wdata,
   output logic [VALUE_BITS-1:0]        mid_a_ff,
   output logic [VALUE_BITS-1:0]        mid_b_ff,
   output logic [VALUE_BITS-1:0]        up_ff,
   output logic [VALUE_BITS-1:0]        left_ff
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);

   logic [VALUE_BITS-1:0] middle_mem [MAX_WIDTH];
   logic [VALUE_BITS-1:0] upper_mem  [MAX_WIDTH];

   logic                  pend_ff, pend_in;
   logic [COL_BITS-1:0]   pend_col_ff;

   // middle row: read old cell and right neighbor, write the new cell
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mid_a_ff <= middle_mem[addr_a];
         mid_b_ff <= middle_mem[addr_b];
         if (sample) begin
            middle_mem[addr_a] <= wdata;
         end
      end
   end

   // upper row: the old middle cell moves up once its read data is in
   always_ff @(posedge clock) begin
      if (rd_en) begin
         up_ff <= upper_mem[addr_a];
      end
      if (pend_ff) begin
         upper_mem[pend_col_ff] <= mid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en && sample) begin
         left_ff     <= mid_a_ff;
         pend_col_ff <= addr_a;
      end
   end

   assign pend_in = rd_en ? sample : pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

endmodule

[sv/jfp_relax.sv]
// ----------------------------------------------------------------------------
// jfp_relax
// Stencil mean, change check against tolerance and result register, with
// per-stage flow control.
// ----------------------------------------------------------------------------
module jfp_relax import jfp_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  restart,
   input  logic [TOL_BITS-1:0]   tolerance,
   input  item_ctl_type          item_ctl,
   input  logic [VALUE_BITS-1:0] sample_value,
   input  logic [VALUE_BITS-1:0] mid_a,
   input  logic [VALUE_BITS-1:0] mid_b,
   input  logic [VALUE_BITS-1:0] up,
   input  logic [VALUE_BITS-1:0] left,
   output logic                  in_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload
);

   localparam int SUM_BITS = VALUE_BITS + 2;
   localparam int EXT_BITS = (VALUE_BITS > TOL_BITS) ? VALUE_BITS : TOL_BITS;

   logic                  v1_ff, v1_in;
   logic                  int1_ff, last1_ff;
   logic [VALUE_BITS-1:0] s1_ff;

   logic                  v2_ff, v2_in;
   logic                  int2_ff, last2_ff;
   logic [VALUE_BITS-1:0] mean2_ff, old2_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_ff, rsp_in;
   logic                  all_ok_ff, all_ok_in;

   logic                  rdy2, rdy3, adv2, adv3;
   logic                  load1;
   logic [SUM_BITS-1:0]   sum;
   logic [VALUE_BITS-1:0] diff;
   logic [VALUE_BITS-1:0] value;
   logic                  below_tol;

   assign rdy3     = !rsp_valid_ff || !rsp_stall;
   assign rdy2     = !v2_ff || rdy3;
   assign in_ready = !v1_ff || rdy2;
   assign adv2     = v1_ff && rdy2;
   assign adv3     = v2_ff && rdy3;
   assign load1    = item_ctl.load && item_ctl.emit;

   assign v1_in        = load1 || (v1_ff && !rdy2);
   assign v2_in        = adv2 || (v2_ff && !rdy3);
   assign rsp_valid_in = adv3 || (rsp_valid_ff && rsp_stall);

   // four-point sum, exact; the mean is its top bits
   assign sum = SUM_BITS'(up) + SUM_BITS'(left) + SUM_BITS'(mid_b) + SUM_BITS'(s1_ff);

   always_comb begin
      diff      = (mean2_ff >= old2_ff) ? mean2_ff - old2_ff : old2_ff - mean2_ff;
      below_tol = EXT_BITS'(diff) < EXT_BITS'(tolerance);
      value     = int2_ff ? mean2_ff : old2_ff;
      rsp_in.new_value     = DATA_BITS'(value);
      rsp_in.converged     = last2_ff && all_ok_ff;
      rsp_in.last_of_sweep = last2_ff;
   end

   always_comb begin
      all_ok_in = all_ok_ff;
      if (restart) begin
         all_ok_in = 1'b1;
      end else if (adv3 && last2_ff) begin
         all_ok_in = 1'b1;
      end else if (adv3 && int2_ff && !below_tol) begin
         all_ok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         int1_ff  <= item_ctl.interior;
         last1_ff <= item_ctl.last;
         s1_ff    <= sample_value;
      end
      if (adv2) begin
         int2_ff  <= int1_ff;
         last2_ff <= last1_ff;
         mean2_ff <= sum[SUM_BITS-1:2];
         old2_ff  <= mid_a;
      end
      if (adv3) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         all_ok_ff    <= 1'b1;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
         all_ok_ff    <= all_ok_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_conv_only_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.converged) |-> rsp_ff.last_of_sweep)
      else $error("converged flag on a result that does not close the sweep");

   a_conv_rearm: assert property (@(posedge clock) disable iff (reset)
      (adv3 && last2_ff) |=> all_ok_ff)
      else $error("convergence flag not rearmed after end of sweep");
`endif

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for jacobi_four_point_sweep: drives raster grids of
// Q16.16 cells with drain beats, out-of-turn beats, register writes between
// sweeps and random handshake gaps, and compares every result beat with a
// cycle-free predictor of the relaxation sweep.
// ----------------------------------------------------------------------------

class relax_scoreboard;
   logic [jfp_pkg::DATA_BITS-1:0]        upper_row [jfp_pkg::MAX_WIDTH_DEF];
   logic [jfp_pkg::DATA_BITS-1:0]        middle_row [jfp_pkg::MAX_WIDTH_DEF];
   int unsigned                          col;
   int unsigned                          row;
   int unsigned                          drained;
   bit                                   all_within;
   logic [jfp_pkg::GRID_WIDTH_BITS-1:0]  width_reg;
   logic [jfp_pkg::GRID_HEIGHT_BITS-1:0] height_reg;
   logic [jfp_pkg::TOL_BITS-1:0]         tol_reg;
   jfp_pkg::rsp_payload_type             expected_cells [$];
   int unsigned                          errors;

   function new();
      foreach (upper_row[i]) begin
         upper_row[i]  = '0;
         middle_row[i] = '0;
      end
      width_reg  = jfp_pkg::GRID_WIDTH_RST;
      height_reg = jfp_pkg::GRID_HEIGHT_RST;
      tol_reg    = jfp_pkg::TOLERANCE_RST;
      errors     = 0;
      restart_sweep();
   endfunction

   function void restart_sweep();
      col        = 0;
      row        = 0;
      drained    = 0;
      all_within = 1'b1;
   endfunction

   function int unsigned eff_width();
      if (width_reg < jfp_pkg::MIN_DIM) return jfp_pkg::MIN_DIM;
      if (width_reg > jfp_pkg::MAX_WIDTH_DEF) return jfp_pkg::MAX_WIDTH_DEF;
      return width_reg;
   endfunction

   function int unsigned eff_height();
      if (height_reg < jfp_pkg::MIN_DIM) return jfp_pkg::MIN_DIM;
      return height_reg;
   endfunction

   function int unsigned pending();
      return expected_cells.size();
   endfunction

   function void write_reg(logic [jfp_pkg::CSR_INDEX_BITS-1:0] index,
                           logic [jfp_pkg::CSR_DATA_BITS-1:0] data);
      case (index)
         jfp_pkg::CSR_GRID_WIDTH: begin
            width_reg = data[jfp_pkg::GRID_WIDTH_BITS-1:0];
         end
         jfp_pkg::CSR_GRID_HEIGHT: begin
            height_reg = data[jfp_pkg::GRID_HEIGHT_BITS-1:0];
         end
         jfp_pkg::CSR_TOLERANCE: begin
            tol_reg = data[jfp_pkg::TOL_BITS-1:0];
         end
         default: return;
      endcase
      restart_sweep();
   endfunction

   // exact floor of the four-neighbor mean
   function logic [jfp_pkg::DATA_BITS-1:0] mean_of_four(
      logic [jfp_pkg::DATA_BITS-1:0] a, logic [jfp_pkg::DATA_BITS-1:0] b,
      logic [jfp_pkg::DATA_BITS-1:0] c, logic [jfp_pkg::DATA_BITS-1:0] d);
      logic [jfp_pkg::DATA_BITS+1:0] total;
      total = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
      return total[jfp_pkg::DATA_BITS+1:2];
   endfunction

   function void note_beat(jfp_pkg::req_payload_type beat);
      int unsigned                   w;
      int unsigned                   h;
      int unsigned                   c;
      logic [jfp_pkg::DATA_BITS-1:0] old_mid;
      logic [jfp_pkg::DATA_BITS-1:0] old_up;
      logic [jfp_pkg::DATA_BITS-1:0] diff;
      jfp_pkg::rsp_payload_type      outcome;
      w = eff_width();
      h = eff_height();
      outcome = '0;
      if (beat.drain) begin
         // drop drains until the final row is complete
         if (row != h || drained >= w) return;
         outcome.new_value = middle_row[drained];
         if (drained == w - 1) begin
            outcome.converged     = all_within;
            outcome.last_of_sweep = 1'b1;
            restart_sweep();
         end else begin
            drained++;
         end
         expected_cells.push_back(outcome);
         return;
      end
      // drop samples once every cell of the grid is in
      if (row >= h || col >= w) return;
      c = col;
      old_mid = middle_row[c];
      old_up  = upper_row[c];
      upper_row[c]  = old_mid;
      middle_row[c] = beat.sample_value;
      if (row >= 1) begin
         outcome.new_value = old_mid;
         if (row - 1 >= 1 && row - 1 <= h - 2 && c >= 1 && c <= w - 2) begin
            outcome.new_value = mean_of_four(old_up, upper_row[c-1], middle_row[c+1],
                                             beat.sample_value);
            diff = outcome.new_value > old_mid ? outcome.new_value - old_mid
                                               : old_mid - outcome.new_value;
            if (!(diff < tol_reg)) all_within = 1'b0;
         end
         expected_cells.push_back(outcome);
      end
      if (c == w - 1) begin
         col = 0;
         row++;
      end else begin
         col++;
      end
   endfunction

   function void report(string what, logic [jfp_pkg::DATA_BITS-1:0] want,
                        logic [jfp_pkg::DATA_BITS-1:0] got);
      $display("%0t: %s mismatch: expected %h actual %h", $time, what, want, got);
      errors++;
   endfunction

   function void check_result(jfp_pkg::rsp_payload_type got);
      jfp_pkg::rsp_payload_type want;
      if (expected_cells.size() == 0) begin
         $display("%0t: unexpected result: expected none actual %h/%b/%b", $time,
                  got.new_value, got.converged, got.last_of_sweep);
         errors++;
         return;
      end
      want = expected_cells.pop_front();
      if (got.new_value !== want.new_value)
         report("new_value", want.new_value, got.new_value);
      if (got.converged !== want.converged)
         report("converged", want.converged, got.converged);
      if (got.last_of_sweep !== want.last_of_sweep)
         report("last_of_sweep", want.last_of_sweep, got.last_of_sweep);
   endfunction
endclass

module testbench;
   import jfp_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 250;
   localparam int IDLE_LIMIT    = 2000;
   localparam int ITEM_TARGET   = 1800;
   localparam int NEVER         = 32'hFFFF_FFFF;

   typedef enum {STYLE_NOISE, STYLE_SMOOTH, STYLE_EXTREME, STYLE_FLAT} grid_style_type;
   typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_style_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   req_payload_type           req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   rsp_payload_type           rsp_payload;
   logic                      csr_wr_en   = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata   = '0;

   relax_scoreboard sb = new();
   bit              hold_request  = 1'b0;
   bit              steady_sender = 1'b0;
   int unsigned     burst_left    = 0;
   int unsigned     effective_items = 0;
   int unsigned     idle_cycles   = 0;

   jacobi_four_point_sweep uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // check results before noting inputs: a beat taken now cannot answer yet
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) sb.check_result(rsp_payload);
         if (req_valid === 1'b1 && req_stall === 1'b0) sb.note_beat(req_payload);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
               $display("FAIL jacobi_four_point_sweep");
               $finish;
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off on request
   initial begin
      int unsigned  seg_len;
      int unsigned  period;
      int unsigned  on_len;
      int unsigned  k;
      rx_style_type style;
      forever begin
         seg_len = $urandom_range(10, 150);
         style   = rx_style_type'($urandom_range(0, 3));
         period  = $urandom_range(2, 9);
         on_len  = $urandom_range(1, period - 1);
         for (k = 0; k < seg_len; k++) begin
            @(negedge clock);
            if (hold_request) begin
               hold_request = 1'b0;
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES - 1) begin
                  @(negedge clock);
                  rsp_stall <= 1'b1;
               end
            end else begin
               case (style)
                  RX_FREE:     rsp_stall <= 1'b0;
                  RX_LIGHT:    rsp_stall <= ($urandom_range(0, 9) < 3);
                  RX_HEAVY:    rsp_stall <= ($urandom_range(0, 9) < 7);
                  RX_PERIODIC: rsp_stall <= ((k % period) < on_len);
                  default:     rsp_stall <= 1'b0;
               endcase
            end
         end
      end
   end

   task automatic send_beat(input req_payload_type beat);
      int unsigned gap;
      gap = 0;
      if (!steady_sender) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            burst_left = $urandom_range(1, 30);
         end
         burst_left--;
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   task automatic send_cell(input logic [DATA_BITS-1:0] value, input bit is_drain,
                            input bit counts);
      req_payload_type beat;
      beat.sample_value = value;
      beat.drain        = is_drain;
      send_beat(beat);
      if (counts) effective_items++;
   endtask

   // drop valid and wait until every result is out and the pipe is quiet
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(index, data);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [DATA_BITS-1:0] cell_value(grid_style_type style,
                                                       logic [DATA_BITS-1:0] base);
      case (style)
         STYLE_NOISE:  return $urandom;
         STYLE_SMOOTH: return base + $urandom_range(0, 3000);
         STYLE_FLAT:   return base;
         default: begin
            case ($urandom_range(0, 3))
               0:       return 32'h0000_0000;
               1:       return 32'hFFFF_FFFF;
               2:       return 32'hFFFF_FFFC;
               default: return 32'h0000_0003;
            endcase
         end
      endcase
   endfunction

   task automatic run_sweep(input int unsigned w, input int unsigned h,
                            input int unsigned rows_to_send, input bit drain_it,
                            input grid_style_type style, input bit force_pause);
      logic [DATA_BITS-1:0] base;
      int unsigned          pause_at;
      int unsigned          beat_idx;
      int unsigned          r;
      int unsigned          c;
      base = $urandom;
      beat_idx = 0;
      pause_at = (force_pause || $urandom_range(0, 3) == 0) ?
                 $urandom_range(0, w * rows_to_send - 1) : NEVER;
      for (r = 0; r < rows_to_send; r++) begin
         for (c = 0; c < w; c++) begin
            // drain out of turn: taken and dropped
            if ($urandom_range(0, 29) == 0) send_cell($urandom, 1'b1, 1'b0);
            if (beat_idx == pause_at) begin
               wait_idle();
               if ($urandom_range(0, 1)) write_reg(CSR_UNUSED, $urandom);
            end
            send_cell(cell_value(style, base), 1'b0, 1'b1);
            beat_idx++;
         end
      end
      if (drain_it) begin
         // samples past the grid: taken and dropped
         repeat ($urandom_range(0, 2)) send_cell($urandom, 1'b0, 1'b0);
         repeat (w) send_cell($urandom, 1'b1, 1'b1);
      end
   endtask

   initial begin
      int unsigned          phase;
      int unsigned          w;
      int unsigned          h;
      int unsigned          sweeps;
      int unsigned          rows;
      int unsigned          i;
      logic [DATA_BITS-1:0] width_val;
      logic [DATA_BITS-1:0] height_val;
      logic [DATA_BITS-1:0] tol_val;
      logic [DATA_BITS-1:0] small_grid [9];
      bit                   partial;
      grid_style_type       style;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: 3 x 3 from out-of-range settings, all-ones neighbors, zero tolerance
      write_reg(CSR_GRID_WIDTH, 32'd2);
      write_reg(CSR_GRID_HEIGHT, 32'd0);
      write_reg(CSR_TOLERANCE, 32'd0);
      send_cell($urandom, 1'b1, 1'b0);
      for (i = 0; i < 9; i++) send_cell(i == 4 ? 32'h0 : 32'hFFFF_FFFF, 1'b0, 1'b1);
      send_cell($urandom, 1'b0, 1'b0);
      repeat (3) send_cell($urandom, 1'b1, 1'b1);
      wait_idle();

      // directed: truncated mean, widest tolerance, upper data bits ignored
      write_reg(CSR_TOLERANCE, 32'hFFFF_FFFF);
      write_reg(CSR_GRID_WIDTH, 32'hFFFF_FF83);
      write_reg(CSR_GRID_HEIGHT, 32'hABCD_0003);
      small_grid = '{32'd0, 32'd1, 32'd0, 32'd2, 32'd7, 32'd3, 32'd0, 32'd5, 32'd0};
      for (i = 0; i < 9; i++) send_cell(small_grid[i], 1'b0, 1'b1);
      repeat (3) send_cell($urandom, 1'b1, 1'b1);
      wait_idle();

      phase = 0;
      // run at least through the phase with the long receiver hold-off
      while (effective_items < ITEM_TARGET || phase < 3) begin
         phase++;
         case ($urandom_range(0, 9))
            0:       width_val = $urandom_range(0, 2);
            1:       width_val = $urandom_range(65, 127);
            2:       width_val = 64;
            3:       width_val = $urandom_range(17, 63);
            default: width_val = $urandom_range(3, 16);
         endcase
         case ($urandom_range(0, 19))
            0, 1:    height_val = $urandom_range(0, 2);
            2:       height_val = 16'hFFFF;
            3:       height_val = $urandom_range(7, 20);
            default: height_val = $urandom_range(3, 6);
         endcase
         case ($urandom_range(0, 5))
            0:       tol_val = 32'h0;
            1:       tol_val = 32'hFFFF_FFFF;
            2:       tol_val = TOLERANCE_RST;
            3:       tol_val = $urandom_range(0, 20000);
            default: tol_val = $urandom;
         endcase
         if (phase == 3) begin
            width_val  = 16;
            height_val = 6;
         end
         if ($urandom_range(0, 3) == 0) width_val = width_val | ($urandom << 7);
         if ($urandom_range(0, 5) == 0) write_reg(CSR_UNUSED, $urandom);
         write_reg(CSR_GRID_WIDTH, width_val);
         write_reg(CSR_GRID_HEIGHT, height_val);
         write_reg(CSR_TOLERANCE, tol_val);
         w = sb.eff_width();
         h = sb.eff_height();

         steady_sender = (phase == 3) || ($urandom_range(0, 3) == 0);
         // let the result side sit still while the sender keeps pushing
         if (phase == 3) hold_request = 1'b1;

         partial = (h > 20) || ($urandom_range(0, 7) == 0);
         sweeps  = partial ? 1 : $urandom_range(1, 3);
         repeat (sweeps) begin
            style = grid_style_type'($urandom_range(0, 3));
            rows  = (h > 20) ? $urandom_range(2, 4) :
                    partial  ? $urandom_range(1, h - 1) : h;
            run_sweep(w, h, rows, !partial, style, phase == 1);
         end
         wait_idle();
      end

      steady_sender = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS jacobi_four_point_sweep");
      end else begin
         $display("FAIL jacobi_four_point_sweep");
      end
      $finish;
   end

endmodule
